[design/sdps_pkg.sv]
// Shared constants, register indexes and a helper function of the spike detector.
package sdps_pkg;

    localparam int DEF_RING_DEPTH     = 128;
    localparam int DEF_EXTEND_SAMPLES = 5;
    localparam int DEF_INDEX_BITS     = 24;

    localparam int SAMPLE_W    = 16;
    localparam int AMP_W       = 16;
    localparam int TIME_W      = 24;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int WINDOW_W    = 7;
    localparam int MAX_RESULTS = 37;
    localparam int COUNT_W     = 6;
    localparam int WINDOW_CAP  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_NEG  = 2'd3;

    localparam logic [15:0] RST_THRESHOLD  = 16'd1000;
    localparam logic [6:0]  RST_WINDOW     = 7'd20;
    localparam logic [15:0] RST_REFRACTORY = 16'd30;

    // Magnitude of a signed sample; the most negative code needs the 17th bit.
    function automatic logic [SAMPLE_W:0] mag17(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W:0] w;
        w = {v[SAMPLE_W-1], v};
        return w[SAMPLE_W] ? (SAMPLE_W+1)'(-w) : (SAMPLE_W+1)'(w);
    endfunction

endpackage

[design/sdps_sample_if.sv]
// Input and result channel interfaces of the spike detector.
interface sdps_sample_if;
    import sdps_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       record_end;
    modport source (output valid, output sample, output record_end, input ready);
    modport sink   (input valid, input sample, input record_end, output ready);
endinterface

interface sdps_result_if;
    import sdps_pkg::*;
    logic              valid;
    logic              ready;
    logic              spike_valid;
    logic [AMP_W-1:0]  spike_amplitude;
    logic [TIME_W-1:0] spike_time;
    logic              run_last;
    modport source (output valid, output spike_valid, output spike_amplitude,
                    output spike_time, output run_last, input ready);
    modport sink   (input valid, input spike_valid, input spike_amplitude,
                    input spike_time, input run_last, output ready);
endinterface

[design/spike_detect_ptsd_swap.sv]
// Top level of the streaming peak-to-peak spike detector.
//
// The block takes one signed sample per item and keeps the recent samples of
// the recording in a ring memory. Each position is examined once enough later
// samples are known: a local peak of magnitude starts a search over the peak
// window for the opposite extreme, the start peak is re-picked, the pair is
// swapped if reversed, and the search is extended when the end sits on the
// window edge. A peak-to-peak difference at or above the threshold yields a
// result item with amplitude and timestamp; scanning then skips by the
// refractory time. On the record_end item all remaining positions are
// examined, the final result carries run_last (or a bare marker is sent), and
// the next item starts a new recording. Every sample value is fetched through
// the single read port of the ring memory under a small sequencer, so the
// block is busy while an item is processed and takes no new item before it
// is done. Up to two result items wait, one in the output register and one
// held back until it is known whether it ends the item, so a stalled sink
// holds the sequencer only when a further spike is found while both are
// occupied, or when the item ends while the held-back result or a bare
// marker cannot move to the output register.
module spike_detect_ptsd_swap #(
    parameter int RING_DEPTH     = sdps_pkg::DEF_RING_DEPTH,
    parameter int EXTEND_SAMPLES = sdps_pkg::DEF_EXTEND_SAMPLES,
    parameter int INDEX_BITS     = sdps_pkg::DEF_INDEX_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sdps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdps_pkg::CFG_DATA_W-1:0]  cfg_data,
    sdps_sample_if.sink                      samples,
    sdps_result_if.source                    results
);
    import sdps_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int IB = INDEX_BITS;
    localparam int PW_LIMIT = ((RING_DEPTH - EXTEND_SAMPLES - 2) < WINDOW_CAP) ?
                              (RING_DEPTH - EXTEND_SAMPLES - 2) : WINDOW_CAP;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOOP  = 4'd1;
    localparam logic [3:0] S_E0    = 4'd2;
    localparam logic [3:0] S_E1    = 4'd3;
    localparam logic [3:0] S_E2    = 4'd4;
    localparam logic [3:0] S_E3    = 4'd5;
    localparam logic [3:0] S_R1    = 4'd6;
    localparam logic [3:0] S_C1    = 4'd7;
    localparam logic [3:0] S_R2    = 4'd8;
    localparam logic [3:0] S_C2    = 4'd9;
    localparam logic [3:0] S_SWAP  = 4'd10;
    localparam logic [3:0] S_R3    = 4'd11;
    localparam logic [3:0] S_C3    = 4'd12;
    localparam logic [3:0] S_DEC   = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;
    localparam logic [3:0] S_FLUSH = 4'd15;

    // Configuration registers.
    logic [15:0]         thr_reg;
    logic [WINDOW_W-1:0] pw_reg;
    logic [15:0]         refr_reg;
    logic                alneg_reg;

    // Sequencer and position state.
    logic [3:0]    state_reg;
    logic [IB-1:0] seen_reg, scan_reg, resume_reg;
    logic [IB-1:0] idx_reg, i_reg, st_reg, et_reg, lim_reg;
    logic [AW-1:0] wptr_reg;
    logic          ended_reg, pos_reg, magok_reg;
    logic signed [SAMPLE_W-1:0] sv_reg, ev_reg;
    logic [COUNT_W-1:0] n_reg;

    // Candidate, pending and output results.
    logic [AMP_W-1:0]  cand_amp_reg, pend_amp_reg;
    logic [TIME_W-1:0] cand_time_reg, pend_time_reg;
    logic              pend_valid_reg;
    logic              out_valid_reg, out_spike_reg, out_last_reg;
    logic [AMP_W-1:0]  out_amp_reg;
    logic [TIME_W-1:0] out_time_reg;

    // Ring memory with a registered read port.
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic [IB-1:0] rd_pos, last_pos, clamp_pos, back_dist;
    logic [AW-1:0] last_ptr, raddr;
    logic [AW:0]   raw_addr, wrap_addr;
    logic          ring_we;

    logic [WINDOW_W-1:0] wl;
    logic                out_free;
    logic                out_load;
    logic                in_take;

    assign samples.ready = (state_reg == S_IDLE);
    assign in_take       = samples.valid && samples.ready;
    assign ring_we       = in_take;
    assign out_free      = !out_valid_reg || results.ready;

    assign results.valid           = out_valid_reg;
    assign results.spike_valid     = out_spike_reg;
    assign results.spike_amplitude = out_amp_reg;
    assign results.spike_time      = out_time_reg;
    assign results.run_last        = out_last_reg;

    // The output register is loaded when a held-back spike moves on or when
    // the item ends with a bare marker.
    assign out_load = ((state_reg == S_EMIT) && pend_valid_reg && out_free) ||
                      ((state_reg == S_FLUSH) && out_free && (pend_valid_reg || ended_reg));

    // Effective window: zero acts as one, large values saturate.
    always_comb
    begin
        if (pw_reg == '0)
            wl = WINDOW_W'(1);
        else if (32'(pw_reg) > PW_LIMIT)
            wl = WINDOW_W'(PW_LIMIT);
        else
            wl = pw_reg;
    end

    // Position fetched by the state that issues a read.
    always_comb
    begin
        case (state_reg)
            S_E0:                rd_pos = idx_reg;
            S_E1:                rd_pos = idx_reg - IB'(1);
            S_E2:                rd_pos = idx_reg + IB'(1);
            S_R1, S_R2, S_R3:    rd_pos = i_reg;
            default:             rd_pos = idx_reg;
        endcase
    end

    // Reads past the last sample return the last sample. The ring address is
    // found by stepping back from the newest entry, since the distance stays
    // below the ring depth.
    always_comb
    begin
        last_pos  = seen_reg - IB'(1);
        clamp_pos = (rd_pos > last_pos) ? last_pos : rd_pos;
        back_dist = last_pos - clamp_pos;
        last_ptr  = (wptr_reg == '0) ? AW'(RING_DEPTH - 1) : wptr_reg - AW'(1);
        raw_addr  = {1'b0, last_ptr} - back_dist[AW:0];
        wrap_addr = raw_addr + (AW+1)'(RING_DEPTH);
        raddr     = raw_addr[AW] ? wrap_addr[AW-1:0] : raw_addr[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[wptr_reg] <= samples.sample;
        rdata_reg <= ring_mem[raddr];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= RST_THRESHOLD;
            pw_reg    <= RST_WINDOW;
            refr_reg  <= RST_REFRACTORY;
            alneg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  thr_reg   <= cfg_data[15:0];
                REG_WINDOW:     pw_reg    <= cfg_data[WINDOW_W-1:0];
                REG_REFRACTORY: refr_reg  <= cfg_data[15:0];
                REG_ALIGN_NEG:  alneg_reg <= cfg_data[0];
                default:        thr_reg   <= thr_reg;
            endcase
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // Working values of the sequencer.
    logic [IB:0]   eff_wide, need_wide, lim_ext, target_wide;
    logic [IB-1:0] eff_pos, span, iv;
    logic          scan_done, better_end, better_start, extend_ok;
    logic signed [SAMPLE_W:0] pp_diff;
    logic [SAMPLE_W:0]        pp_mag;
    logic [IB-1:0]            ts;

    always_comb
    begin
        eff_pos   = (scan_reg < resume_reg) ? resume_reg : scan_reg;
        eff_wide  = {1'b0, eff_pos};
        need_wide = eff_wide + (IB+1)'(wl) + (IB+1)'(EXTEND_SAMPLES);
        scan_done = ended_reg ? (eff_pos >= seen_reg) : (need_wide >= {1'b0, seen_reg});
        span      = seen_reg - idx_reg;
        iv        = (ended_reg && (span < IB'(wl))) ? span : IB'(wl);
        lim_ext   = {1'b0, lim_reg} + (IB+1)'(EXTEND_SAMPLES);
        extend_ok = (EXTEND_SAMPLES > 0) && (et_reg == lim_reg) &&
                    (!ended_reg || (lim_ext < {1'b0, seen_reg}));
        better_end   = pos_reg ? (rdata_reg < ev_reg) : (rdata_reg > ev_reg);
        better_start = pos_reg ? (rdata_reg > sv_reg) : (rdata_reg < sv_reg);
        pp_diff = {sv_reg[SAMPLE_W-1], sv_reg} - {ev_reg[SAMPLE_W-1], ev_reg};
        pp_mag  = pp_diff[SAMPLE_W] ? (SAMPLE_W+1)'(-pp_diff) : (SAMPLE_W+1)'(pp_diff);
        if (!alneg_reg)
            ts = (mag17(sv_reg) > mag17(ev_reg)) ? st_reg : et_reg;
        else
            ts = (sv_reg < ev_reg) ? st_reg : et_reg;
        target_wide = {1'b0, ts} + (IB+1)'(refr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seen_reg       <= '0;
            scan_reg       <= IB'(1);
            resume_reg     <= IB'(1);
            wptr_reg       <= '0;
            ended_reg      <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            i_reg          <= '0;
            st_reg         <= '0;
            et_reg         <= '0;
            lim_reg        <= '0;
            pos_reg        <= 1'b0;
            magok_reg      <= 1'b0;
            sv_reg         <= '0;
            ev_reg         <= '0;
            cand_amp_reg   <= '0;
            cand_time_reg  <= '0;
            pend_amp_reg   <= '0;
            pend_time_reg  <= '0;
            out_spike_reg  <= 1'b0;
            out_amp_reg    <= '0;
            out_time_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        seen_reg  <= seen_reg + IB'(1);
                        wptr_reg  <= (wptr_reg == AW'(RING_DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
                        ended_reg <= samples.record_end;
                        n_reg     <= '0;
                        state_reg <= S_LOOP;
                    end
                end
                S_LOOP:
                begin
                    scan_reg  <= eff_pos;
                    idx_reg   <= eff_pos;
                    state_reg <= scan_done ? S_FLUSH : S_E0;
                end
                S_E0:
                    state_reg <= S_E1;
                S_E1:
                begin
                    sv_reg    <= rdata_reg;
                    ev_reg    <= rdata_reg;
                    pos_reg   <= (rdata_reg > 0);
                    scan_reg  <= idx_reg + IB'(1);
                    state_reg <= S_E2;
                end
                S_E2:
                begin
                    magok_reg <= (mag17(sv_reg) > mag17(rdata_reg));
                    state_reg <= S_E3;
                end
                S_E3:
                begin
                    if (magok_reg && (mag17(sv_reg) >= mag17(rdata_reg)))
                    begin
                        lim_reg   <= idx_reg + iv;
                        st_reg    <= idx_reg;
                        et_reg    <= idx_reg + IB'(1);
                        i_reg     <= idx_reg + IB'(1);
                        state_reg <= S_R1;
                    end
                    else
                        state_reg <= S_LOOP;
                end
                S_R1:
                    state_reg <= S_C1;
                S_C1:
                begin
                    if (better_end)
                    begin
                        et_reg <= i_reg;
                        ev_reg <= rdata_reg;
                    end
                    if (i_reg == lim_reg)
                    begin
                        i_reg     <= idx_reg + IB'(1);
                        state_reg <= ((idx_reg + IB'(1)) < lim_reg) ? S_R2 : S_SWAP;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IB'(1);
                        state_reg <= S_R1;
                    end
                end
                S_R2:
                    state_reg <= S_C2;
                S_C2:
                begin
                    if (better_start)
                    begin
                        st_reg <= i_reg;
                        sv_reg <= rdata_reg;
                    end
                    i_reg     <= i_reg + IB'(1);
                    state_reg <= ((i_reg + IB'(1)) == lim_reg) ? S_SWAP : S_R2;
                end
                S_SWAP:
                begin
                    // Start and end values are the samples at their positions,
                    // so a reversed pair swaps without new reads.
                    if (et_reg < st_reg)
                    begin
                        st_reg    <= et_reg;
                        et_reg    <= st_reg;
                        sv_reg    <= ev_reg;
                        ev_reg    <= sv_reg;
                        state_reg <= S_DEC;
                    end
                    else if (extend_ok)
                    begin
                        i_reg     <= lim_reg + IB'(1);
                        state_reg <= S_R3;
                    end
                    else
                        state_reg <= S_DEC;
                end
                S_R3:
                    state_reg <= S_C3;
                S_C3:
                begin
                    if (better_end)
                    begin
                        et_reg <= i_reg;
                        ev_reg <= rdata_reg;
                    end
                    i_reg     <= i_reg + IB'(1);
                    state_reg <= ({1'b0, i_reg} == lim_ext) ? S_DEC : S_R3;
                end
                S_DEC:
                begin
                    if (pp_mag[AMP_W-1:0] < thr_reg)
                        state_reg <= S_LOOP;
                    else
                    begin
                        if ((target_wide > {1'b0, et_reg}) &&
                            (!ended_reg || (target_wide < {1'b0, seen_reg})))
                            resume_reg <= target_wide[IB-1:0];
                        else
                            resume_reg <= et_reg + IB'(1);
                        cand_amp_reg  <= pp_mag[AMP_W-1:0];
                        cand_time_reg <= TIME_W'(ts);
                        state_reg     <= (n_reg < COUNT_W'(MAX_RESULTS)) ? S_EMIT : S_LOOP;
                    end
                end
                S_EMIT:
                begin
                    // The newest spike is held back until it is known whether
                    // it is the last one of the item.
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_spike_reg <= 1'b1;
                            out_amp_reg   <= pend_amp_reg;
                            out_time_reg  <= pend_time_reg;
                            out_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_amp_reg   <= cand_amp_reg;
                        pend_time_reg  <= cand_time_reg;
                        n_reg          <= n_reg + COUNT_W'(1);
                        state_reg      <= S_LOOP;
                    end
                end
                S_FLUSH:
                begin
                    if (out_free || (!pend_valid_reg && !ended_reg))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_spike_reg  <= 1'b1;
                            out_amp_reg    <= pend_amp_reg;
                            out_time_reg   <= pend_time_reg;
                            out_last_reg   <= ended_reg;
                            pend_valid_reg <= 1'b0;
                        end
                        else if (ended_reg)
                        begin
                            out_spike_reg <= 1'b0;
                            out_amp_reg   <= '0;
                            out_time_reg  <= '0;
                            out_last_reg  <= 1'b1;
                        end
                        if (ended_reg)
                        begin
                            seen_reg   <= '0;
                            scan_reg   <= IB'(1);
                            resume_reg <= IB'(1);
                            wptr_reg   <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[design/sdps_checker.sv]
// Port-level checker of the spike detector and its bind statement.
module sdps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            spike_valid,
    input logic [sdps_pkg::AMP_W-1:0]      spike_amplitude,
    input logic [sdps_pkg::TIME_W-1:0]     spike_time,
    input logic                            run_last
);
    import sdps_pkg::*;

    // A result that is not taken stays with the same content.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(spike_amplitude) &&
        $stable(spike_time) && $stable(spike_valid) && $stable(run_last))
        else $error("stalled result changed");

    // Every item keeps the sequencer busy for at least the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an accepted item");

    // A bare end marker carries no amplitude or time and closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !spike_valid |-> run_last && spike_amplitude == '0 &&
        spike_time == '0)
        else $error("malformed end marker");

endmodule

bind spike_detect_ptsd_swap sdps_checker u_sdps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (samples.valid),
    .in_ready        (samples.ready),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .spike_valid     (results.spike_valid),
    .spike_amplitude (results.spike_amplitude),
    .spike_time      (results.spike_time),
    .run_last        (results.run_last)
);

[tb/tb_top.sv]
// Self-checking testbench of the streaming spike detector.
`timescale 1ns / 1ps

module tb_top;
    import sdps_pkg::*;

    localparam int RING = 128;
    localparam int EXT = 5;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               record_end;
    } sample_item_t;

    typedef struct packed {
        logic        spike_valid;
        logic [15:0] amplitude;
        logic [23:0] stamp;
        logic        run_last;
    } spike_item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sdps_sample_if samples_ch ();
    sdps_result_if results_ch ();

    spike_detect_ptsd_swap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_ch.sink),
        .results   (results_ch.source)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Pending input items, and the spike results predicted for them.
    sample_item_t pending_samples[$];
    spike_item_t expected_spikes[$];

    // Shadow of the detector state, kept by the predictor.
    int signed shadow_ring[RING];
    longint unsigned seen_count;
    longint unsigned scan_pos;
    longint unsigned resume_pos;
    int unsigned thr_reg;
    int unsigned win_reg;
    int unsigned refr_reg;
    int unsigned alignneg_reg;

    int mismatch_count;
    int cycle_count;
    bit quiet_mode;
    bit hold_sink;
    bit src_pause;
    int src_idle;
    int snk_idle;

    function automatic int signed ring_read(longint unsigned j);
        longint unsigned last;
        last = seen_count - 1;
        if (j > last)
            j = last;
        return shadow_ring[j % RING];
    endfunction

    function automatic int signed magnitude(int signed v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned eff_window();
        int unsigned w;
        int unsigned cap;
        cap = (RING - EXT - 2) < 64 ? (RING - EXT - 2) : 64;
        w = win_reg;
        if (w < 1)
            w = 1;
        if (w > cap)
            w = cap;
        return w;
    endfunction

    // Examines one position; returns 1 with amplitude and stamp on a spike.
    function automatic bit examine_position(longint unsigned idx, bit ended,
                                            output int unsigned amp,
                                            output longint unsigned when);
        longint unsigned nf, iv, st, et, i, tmp, ts, target;
        int signed sv, ev, d;
        bit positive;
        nf = seen_count;
        iv = eff_window();
        st = idx;
        et = idx + 1;
        sv = ring_read(idx);
        ev = sv;
        positive = sv > 0;
        amp = 0;
        when = 0;
        scan_pos = idx + 1;
        if (!(magnitude(sv) > magnitude(ring_read(idx - 1)) &&
              magnitude(sv) >= magnitude(ring_read(idx + 1))))
            return 0;
        if (ended && nf - idx < iv)
            iv = nf - idx;
        for (i = idx + 1; i <= idx + iv; i++)
        begin
            d = ring_read(i);
            if (positive ? (d < ev) : (d > ev))
            begin
                et = i;
                ev = d;
            end
        end
        for (i = idx + 1; i < idx + iv; i++)
        begin
            d = ring_read(i);
            if (positive ? (d > sv) : (d < sv))
            begin
                st = i;
                sv = d;
            end
        end
        if (et < st)
        begin
            tmp = st;
            st = et;
            et = tmp;
            sv = ring_read(st);
            ev = ring_read(et);
        end
        // The end on the window edge extends the search past it.
        if (et == idx + iv && (!ended || idx + iv + EXT < nf))
        begin
            for (i = et + 1; i <= idx + iv + EXT; i++)
            begin
                d = ring_read(i);
                if (positive ? (d < ev) : (d > ev))
                begin
                    et = i;
                    ev = d;
                end
            end
        end
        d = magnitude(sv - ev);
        if (d < thr_reg)
            return 0;
        if (alignneg_reg == 0)
            ts = (magnitude(sv) > magnitude(ev)) ? st : et;
        else
            ts = (sv < ev) ? st : et;
        target = ts + refr_reg;
        // A refractory jump past the known end is not taken.
        if (target > et && (!ended || target < nf))
            resume_pos = target;
        else
            resume_pos = et + 1;
        amp = d & 16'hFFFF;
        when = ts;
        return 1;
    endfunction

    // Predicts the spike results caused by one accepted sample.
    task automatic predict_spikes(sample_item_t it);
        int n;
        int unsigned amp;
        longint unsigned when;
        spike_item_t r;
        n = 0;
        shadow_ring[seen_count % RING] = it.sample;
        seen_count++;
        forever
        begin
            if (scan_pos < resume_pos)
                scan_pos = resume_pos;
            if (it.record_end)
            begin
                if (scan_pos >= seen_count)
                    break;
            end
            else if (scan_pos + eff_window() + EXT >= seen_count)
                break;
            if (examine_position(scan_pos, it.record_end, amp, when) && n < MAX_RESULTS)
            begin
                r.spike_valid = 1'b1;
                r.amplitude = amp[15:0];
                r.stamp = when[23:0];
                r.run_last = 1'b0;
                expected_spikes.push_back(r);
                n++;
            end
        end
        if (it.record_end)
        begin
            if (n == 0)
            begin
                r = '0;
                r.run_last = 1'b1;
                expected_spikes.push_back(r);
            end
            else
                expected_spikes[$].run_last = 1'b1;
            seen_count = 0;
            scan_pos = 1;
            resume_pos = 1;
        end
    endtask

    // Driver: offers the oldest pending item, with random idle bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_ch.valid <= 1'b0;
            samples_ch.sample <= '0;
            samples_ch.record_end <= 1'b0;
            src_idle <= 0;
        end
        else
        begin
            if (samples_ch.valid && samples_ch.ready)
            begin
                predict_spikes(pending_samples.pop_front());
            end
            if (samples_ch.valid && !samples_ch.ready)
            begin
                // Hold the offered item until it is taken.
            end
            else if (src_idle > 0)
            begin
                src_idle <= src_idle - 1;
                samples_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() > 0 && !src_pause)
            begin
                if (!quiet_mode && $urandom_range(0, 9) == 0)
                begin
                    src_idle <= $urandom_range(1, 13) - 1;
                    samples_ch.valid <= 1'b0;
                end
                else
                begin
                    // The next item is the head after any pop done above.
                    samples_ch.valid <= 1'b1;
                    samples_ch.sample <= pending_samples[0].sample;
                    samples_ch.record_end <= pending_samples[0].record_end;
                end
            end
            else
                samples_ch.valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result and paces the sink ready.
    always @(posedge clk or negedge rst_n)
    begin
        spike_item_t got;
        spike_item_t want;
        if (!rst_n)
        begin
            results_ch.ready <= 1'b0;
            snk_idle <= 0;
        end
        else
        begin
            if (results_ch.valid && results_ch.ready)
            begin
                got.spike_valid = results_ch.spike_valid;
                got.amplitude = results_ch.spike_amplitude;
                got.stamp = results_ch.spike_time;
                got.run_last = results_ch.run_last;
                if (expected_spikes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item %p", got);
                end
                else
                begin
                    want = expected_spikes.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (hold_sink)
                results_ch.ready <= 1'b0;
            else if (snk_idle > 0)
            begin
                snk_idle <= snk_idle - 1;
                results_ch.ready <= 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                snk_idle <= $urandom_range(1, 13) - 1;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= 1'b1;
        end
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD:  thr_reg = value & 16'hFFFF;
            REG_WINDOW:     win_reg = value & 7'h7F;
            REG_REFRACTORY: refr_reg = value & 16'hFFFF;
            default:        alignneg_reg = value & 1;
        endcase
    endtask

    // Waits until every item is taken and every result has come, then
    // lets the block settle for the longest examination it can do.
    task automatic drain_block();
        while (pending_samples.size() > 0 || samples_ch.valid || expected_spikes.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 65535));
            default: return $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
        endcase
    endfunction

    // Queues one recording of the given length with spike-like bursts in noise.
    task automatic queue_recording(int len);
        sample_item_t it;
        int amp;
        int k;
        for (int i = 0; i < len; i++)
        begin
            it.record_end = (i == len - 1);
            if ($urandom_range(0, 11) == 0 && i + 4 < len)
            begin
                // A biphasic burst: large positive then large negative swing.
                amp = $urandom_range(500, 32767);
                for (k = 0; k < 3; k++)
                begin
                    it.sample = (k == 0) ? 16'(amp) : (k == 1) ? 16'(-amp) : 16'sd0;
                    it.record_end = 1'b0;
                    pending_samples.push_back(it);
                end
                i += 2;
            end
            else
            begin
                it.sample = random_sample();
                pending_samples.push_back(it);
            end
        end
    endtask

    initial
    begin
        sample_item_t it;
        int total;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_mode = 1'b0;
        hold_sink = 1'b0;
        src_pause = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        seen_count = 0;
        scan_pos = 1;
        resume_pos = 1;
        thr_reg = 1000;
        win_reg = 20;
        refr_reg = 30;
        alignneg_reg = 0;
        foreach (shadow_ring[i])
            shadow_ring[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset settings: extremes, a single-sample
        // recording, a negative-first spike and a record end inside a window.
        it.record_end = 1'b1;
        it.sample = 16'sh7FFF;
        pending_samples.push_back(it);
        it.record_end = 1'b0;
        foreach (shadow_ring[i])
            if (i < 12)
            begin
                it.sample = (i == 3) ? 16'sh8000 : (i == 5) ? 16'sh7FFF :
                            (i == 8) ? -16'sd3000 : (i == 9) ? 16'sd2500 : 16'sd10;
                pending_samples.push_back(it);
            end
        it.sample = 16'sh7FFF;
        it.record_end = 1'b1;
        pending_samples.push_back(it);
        drain_block();

        // Extreme settings: smallest window, zero threshold and refractory, negative alignment.
        write_reg(REG_THRESHOLD, 0);
        write_reg(REG_WINDOW, 0);
        write_reg(REG_REFRACTORY, 0);
        write_reg(REG_ALIGN_NEG, 1);
        queue_recording(10);
        drain_block();

        // Phase loop over several settings, among them the largest values.
        total = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(REG_THRESHOLD, 65535);
                    write_reg(REG_WINDOW, 127);
                    write_reg(REG_REFRACTORY, 65535);
                end
                1:
                begin
                    write_reg(REG_THRESHOLD, 200);
                    write_reg(REG_WINDOW, 64);
                    write_reg(REG_REFRACTORY, 5);
                    write_reg(REG_ALIGN_NEG, 0);
                end
                default:
                begin
                    write_reg(REG_THRESHOLD, $urandom_range(0, 6000));
                    write_reg(REG_WINDOW, $urandom_range(1, 30));
                    write_reg(REG_REFRACTORY, $urandom_range(0, 40));
                    write_reg(REG_ALIGN_NEG, $urandom_range(0, 1));
                end
            endcase
            // No idling in the last phase.
            quiet_mode = (phase == 7);
            if (phase == 3)
                hold_sink = 1'b1;
            for (int r = 0; r < 3; r++)
                queue_recording($urandom_range(5, 35));
            if (phase == 3)
            begin
                // Long sink stall while the source keeps offering items.
                repeat (2000) @(posedge clk);
                hold_sink = 1'b0;
            end
            if (phase == 5)
            begin
                // Source pause until every expected result has come.
                while (pending_samples.size() > 10 || samples_ch.valid)
                    @(posedge clk);
                src_pause = 1'b1;
                while (expected_spikes.size() > 0)
                    @(posedge clk);
                src_pause = 1'b0;
            end
            drain_block();
        end

        if (mismatch_count == 0 && expected_spikes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[files.f]
design/sdps_pkg.sv
design/sdps_sample_if.sv
design/spike_detect_ptsd_swap.sv
design/sdps_checker.sv
tb/tb_top.sv
